>>> sv/spq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the sorted priority queue: the request and
// response words, the operation and status codes and the cell control group.
// ----------------------------------------------------------------------------
package spq_pkg;

    // Operation codes carried in the request word.
    localparam logic KIND_ENQUEUE = 1'b0;
    localparam logic KIND_DEQUEUE = 1'b1;

    // Status codes carried in the response word.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_FULL  = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    // Width of the value fields on the ports.
    localparam int PORT_VALUE_W = 32;

    // Request word.
    typedef struct packed {
        logic                           kind;
        logic signed [PORT_VALUE_W-1:0] value;
    } spq_req_t;

    // Response word.
    typedef struct packed {
        logic signed [PORT_VALUE_W-1:0] out_value;
        logic                           out_valid;
        logic [1:0]                     status;
        logic [31:0]                    access_count;
    } spq_rsp_t;

    // Control broadcast to every cell of the row.
    typedef struct packed {
        logic ins;
        logic rem;
    } spq_ctrl_t;

endpackage : spq_pkg
`default_nettype wire

>>> sv/spq_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell
// One storage cell of the sorted row. It compares its entry with the value
// being inserted and takes its next entry from itself, the new value or a
// neighbour.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                          clk,
    input  wire spq_pkg::spq_ctrl_t            ctrl,
    input  wire logic                          occupied,
    input  wire logic signed [VALUE_WIDTH-1:0] new_value,
    input  wire logic                          left_le,
    input  wire logic signed [VALUE_WIDTH-1:0] left_entry,
    input  wire logic signed [VALUE_WIDTH-1:0] right_entry,
    output logic signed [VALUE_WIDTH-1:0]      entry,
    output logic                               le
);
    import spq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] entry_reg;
    logic signed [VALUE_WIDTH-1:0] entry_next;

    // A held entry that is not greater than the new value stays in front of it.
    assign le    = occupied && (entry_reg <= new_value);
    assign entry = entry_reg;

    // Keep, take the new value at the boundary, shift right behind it, or
    // shift left on removal.
    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (le)
                entry_next = entry_reg;
            else if (left_le)
                entry_next = new_value;
            else
                entry_next = left_entry;
        end
        else if (ctrl.rem)
        begin
            entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

endmodule : spq_cell
`default_nettype wire

>>> sv/sorted_priority_queue_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Bounded min-priority queue held as a sorted row of cells.
// ----------------------------------------------------------------------------
// The queue takes one request word per clock cycle whenever the output
// register is empty or its word is being taken in the same cycle. Its
// response word is presented in the cycle after acceptance from a single
// output register. Every operation completes at once because each cell
// decides its next entry locally from its own compare and its neighbours,
// so the whole row shifts at once; the position encoder feeding the 32-bit
// access counter is the only logic that gathers from every cell. Equal
// values leave in arrival order. Enqueue when full and dequeue when empty
// leave the state untouched and report a status instead.
module sorted_priority_queue_unit #(
    parameter int DEPTH       = 16,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire spq_pkg::spq_req_t req_data,
    output logic                   rsp_valid,
    input  wire logic              rsp_ready,
    output spq_pkg::spq_rsp_t      rsp_data
);
    import spq_pkg::*;

    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = $clog2(DEPTH);

    logic                          accept;
    logic signed [VALUE_WIDTH-1:0] new_value;
    logic signed [VALUE_WIDTH-1:0] entries [DEPTH];
    logic [DEPTH-1:0]              le_vec;
    logic [DEPTH-1:0]              left_le_vec;
    logic [DEPTH-1:0]              occupied_vec;
    spq_ctrl_t                     ctrl;
    logic [IDX_W-1:0]              pos;
    logic [31:0]                   ins_add;
    logic [PORT_VALUE_W-1:0]       front_value;
    logic                          is_full;
    logic                          is_empty;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [31:0]      access_reg;
    logic [31:0]      access_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    spq_rsp_t         rsp_reg;
    spq_rsp_t         rsp_next;

    // Handshake: the output register frees up when its word is taken.
    assign req_ready = !rsp_valid_reg || rsp_ready;
    assign accept    = req_valid && req_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_reg;

    assign is_full  = (count_reg == CNT_W'(DEPTH));
    assign is_empty = (count_reg == '0);

    // Map the port value onto the stored width and the front entry back.
    generate
        if (VALUE_WIDTH >= PORT_VALUE_W)
        begin : g_wide
            assign new_value   = VALUE_WIDTH'({1'b0, req_data.value});
            assign front_value = entries[0][PORT_VALUE_W-1:0];
        end
        else
        begin : g_narrow
            assign new_value   = req_data.value[VALUE_WIDTH-1:0];
            assign front_value = PORT_VALUE_W'({1'b0, entries[0]});
        end
    endgenerate

    // Control broadcast to the row.
    always_comb
    begin
        ctrl.ins = accept && (req_data.kind == KIND_ENQUEUE) && !is_full;
        ctrl.rem = accept && (req_data.kind == KIND_DEQUEUE) && !is_empty;
    end

    // The row of cells, each linked to both neighbours.
    genvar gi;
    generate
        for (gi = 0; gi < DEPTH; gi++)
        begin : g_cell
            assign occupied_vec[gi] = (CNT_W'(gi) < count_reg);
            if (gi == 0)
            begin : g_first
                assign left_le_vec[gi] = 1'b1;
            end
            else
            begin : g_rest
                assign left_le_vec[gi] = le_vec[gi-1];
            end

            spq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .clk         (clk),
                .ctrl        (ctrl),
                .occupied    (occupied_vec[gi]),
                .new_value   (new_value),
                .left_le     (left_le_vec[gi]),
                .left_entry  (entries[(gi == 0) ? 0 : gi - 1]),
                .right_entry (entries[(gi == DEPTH - 1) ? gi : gi + 1]),
                .entry       (entries[gi]),
                .le          (le_vec[gi])
            );
        end
    endgenerate

    // Insert position: the one cell that sits on the boundary reports its index.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (left_le_vec[i] && !le_vec[i])
                pos = pos | IDX_W'(i);
        end
    end

    // Accesses added by an insert: the position, or one less than the count
    // when the value goes to the back. An empty store adds nothing.
    always_comb
    begin
        if (is_empty)
            ins_add = '0;
        else if (CNT_W'(pos) == count_reg)
            ins_add = 32'(count_reg - CNT_W'(1));
        else
            ins_add = 32'(pos);
    end

    // Count, access counter and response word.
    always_comb
    begin
        count_next     = count_reg;
        access_next    = access_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (rsp_valid_reg && rsp_ready)
            rsp_valid_next = 1'b0;
        if (accept)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = '0;
            if (req_data.kind == KIND_ENQUEUE)
            begin
                if (is_full)
                begin
                    rsp_next.status = STATUS_FULL;
                end
                else
                begin
                    count_next  = count_reg + CNT_W'(1);
                    access_next = access_reg + ins_add;
                    rsp_next.status = STATUS_OK;
                end
            end
            else
            begin
                if (is_empty)
                begin
                    rsp_next.status = STATUS_EMPTY;
                end
                else
                begin
                    count_next  = count_reg - CNT_W'(1);
                    access_next = access_reg + 32'd1;
                    rsp_next.status    = STATUS_OK;
                    rsp_next.out_value = front_value;
                    rsp_next.out_valid = 1'b1;
                end
            end
            rsp_next.access_count = access_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            access_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            access_reg    <= access_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

endmodule : sorted_priority_queue_unit
`default_nettype wire
